### design/i2c_master_bit_sequencer_macros.svh
// Assertion macros for the I2C master bit sequencer checker.
// Each macro expands to one labeled concurrent assertion on clk_i with reset rst_ni.
`ifndef I2C_MASTER_BIT_SEQUENCER_MACROS_SVH
`define I2C_MASTER_BIT_SEQUENCER_MACROS_SVH

// Same-cycle implication, off during reset
`define I2CMS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off during reset
`define I2CMS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/i2cms_pkg.sv
// Shared types, constants and the command dispatch table of the I2C master bit sequencer.
// No dependencies.
package i2cms_pkg;

  localparam logic [7:0] AckTimeoutReset = 8'd200;
  localparam logic [3:0] BitsPerByte     = 4'd8;

  typedef enum logic [2:0] {
    CMD_START = 3'd0,
    CMD_STOP  = 3'd1,
    CMD_WRITE = 3'd2,
    CMD_WAIT  = 3'd3,
    CMD_READ  = 3'd4,
    CMD_ACK   = 3'd5,
    CMD_NACK  = 3'd6
  } cmd_e;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_S_A     = 4'd1,
    PH_S_B     = 4'd2,
    PH_P_A     = 4'd3,
    PH_P_B     = 4'd4,
    PH_WR_LOW  = 4'd5,
    PH_WR_HIGH = 4'd6,
    PH_WA_RISE = 4'd7,
    PH_WA_POLL = 4'd8,
    PH_WA_HOLD = 4'd9,
    PH_RD_LOW  = 4'd10,
    PH_RD_HIGH = 4'd11,
    PH_AK_SET  = 4'd12,
    PH_AK_HIGH = 4'd13,
    PH_FINISH  = 4'd14
  } phase_e;

  // First phase of each command; the unused code leaves the block idle
  function automatic phase_e first_phase(input logic [2:0] cmd);
    phase_e ph;
    unique case (cmd)
      CMD_START: ph = PH_S_A;
      CMD_STOP:  ph = PH_P_A;
      CMD_WRITE: ph = PH_WR_LOW;
      CMD_WAIT:  ph = PH_WA_RISE;
      CMD_READ:  ph = PH_RD_LOW;
      CMD_ACK:   ph = PH_AK_SET;
      CMD_NACK:  ph = PH_AK_SET;
      default:   ph = PH_IDLE;
    endcase
    return ph;
  endfunction

endpackage

### design/i2c_master_bit_sequencer.sv
// I2C master bit sequencer: one bit-phase tick in, one pin/status result out.
// Depends on i2cms_pkg.
//
//  channel | handshake               | payload
//  --------+-------------------------+------------------------------------------------
//  tick in | in_valid_i / in_ready_o | cmd_valid_i command_i write_data_i sda_sample_i
//  result  | out_valid_o/out_ready_i | scl_level_o sda_drive_o sda_level_o ready_res_o
//          |                         | done_res_o read_value_o ack_missing_o
//  config  | cfg_we_i (no wait)      | cfg_wdata_i (ack_timeout)
//
// Each tick is accepted, run through the phase logic, and the result lands in
// the output register on the same edge. A new tick is taken
// every cycle while the output register is empty or being drained.
// A stalled result holds the input side only when the output register is full.
// Reset puts the sequencer idle with both pins high and ack_timeout at 200.
module i2c_master_bit_sequencer
  import i2cms_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       cmd_valid_i,
  input  logic [2:0] command_i,
  input  logic [7:0] write_data_i,
  input  logic       sda_sample_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       scl_level_o,
  output logic       sda_drive_o,
  output logic       sda_level_o,
  output logic       ready_res_o,
  output logic       done_res_o,
  output logic [7:0] read_value_o,
  output logic       ack_missing_o
);

  logic [7:0] ack_timeout_q;
  phase_e     phase_q, phase_d, phase_cur;
  logic [3:0] bit_cnt_q, bit_cnt_d, bit_cnt_cur, bit_cnt_inc;
  logic [7:0] shift_q, shift_d, shift_cur;
  logic [7:0] tmo_q, tmo_d, tmo_dec;
  logic [2:0] act_cmd_q, act_cmd_d;
  logic       scl_q, scl_d;
  logic       sda_drv_q, sda_drv_d;
  logic       sda_lvl_q, sda_lvl_d;
  logic [7:0] last_read_q, last_read_d;
  logic       ack_fail_q, ack_fail_d;
  logic       idle, load, done, accept;
  logic       out_valid_q;

  // Accept while the result register is free or drains this cycle
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // Dispatch a new command when idle
  assign idle        = (phase_q == PH_IDLE);
  assign load        = idle && cmd_valid_i && (first_phase(command_i) != PH_IDLE);
  assign phase_cur   = load ? first_phase(command_i) : phase_q;
  assign bit_cnt_cur = load ? 4'd0 : bit_cnt_q;
  assign shift_cur   = load ? ((command_i == CMD_WRITE) ? write_data_i : 8'd0) : shift_q;
  assign act_cmd_d   = load ? command_i : act_cmd_q;
  assign bit_cnt_inc = bit_cnt_cur + 4'd1;
  assign tmo_dec     = tmo_q - 8'd1;

  // Next phase
  always_comb begin
    phase_d = PH_IDLE;
    unique case (phase_cur)
      PH_S_A:     phase_d = PH_S_B;
      PH_P_A:     phase_d = PH_P_B;
      PH_WR_LOW:  phase_d = PH_WR_HIGH;
      PH_WR_HIGH: phase_d = (bit_cnt_inc >= BitsPerByte) ? PH_FINISH : PH_WR_LOW;
      PH_WA_RISE: phase_d = PH_WA_POLL;
      PH_WA_POLL: begin
        if (!sda_sample_i) phase_d = PH_WA_HOLD;
        else if (tmo_dec == 8'd0) phase_d = PH_FINISH;
        else phase_d = PH_WA_POLL;
      end
      PH_WA_HOLD: phase_d = PH_FINISH;
      PH_RD_LOW:  phase_d = PH_RD_HIGH;
      PH_RD_HIGH: phase_d = (bit_cnt_inc >= BitsPerByte) ? PH_FINISH : PH_RD_LOW;
      PH_AK_SET:  phase_d = PH_AK_HIGH;
      PH_AK_HIGH: phase_d = PH_FINISH;
      default:    phase_d = PH_IDLE;
    endcase
  end

  // Pin levels, counters and status for this tick
  always_comb begin
    scl_d       = scl_q;
    sda_drv_d   = sda_drv_q;
    sda_lvl_d   = sda_lvl_q;
    bit_cnt_d   = bit_cnt_cur;
    shift_d     = shift_cur;
    tmo_d       = tmo_q;
    last_read_d = last_read_q;
    ack_fail_d  = ack_fail_q;
    done        = 1'b0;
    unique case (phase_cur)
      PH_S_A: begin
        sda_drv_d = 1'b1; sda_lvl_d = 1'b1; scl_d = 1'b1;
      end
      PH_S_B: begin
        sda_lvl_d = 1'b0; done = 1'b1;
      end
      PH_P_A: begin
        sda_drv_d = 1'b1; sda_lvl_d = 1'b0; scl_d = 1'b1;
      end
      PH_P_B: begin
        sda_lvl_d = 1'b1; done = 1'b1;
      end
      PH_WR_LOW: begin
        scl_d = 1'b0; sda_drv_d = 1'b1;
        sda_lvl_d = shift_cur[7];
        shift_d = {shift_cur[6:0], 1'b0};
      end
      PH_WR_HIGH: begin
        scl_d = 1'b1; bit_cnt_d = bit_cnt_inc;
      end
      PH_WA_RISE: begin
        sda_drv_d = 1'b0; scl_d = 1'b1; tmo_d = ack_timeout_q;
      end
      PH_WA_POLL: begin
        scl_d = 1'b1;
        if (sda_sample_i) begin
          tmo_d = tmo_dec;
          if (tmo_dec == 8'd0) ack_fail_d = 1'b1;
        end else begin
          ack_fail_d = 1'b0;
        end
      end
      PH_WA_HOLD: scl_d = 1'b1;
      PH_RD_LOW: begin
        sda_drv_d = 1'b0; sda_lvl_d = 1'b1; scl_d = 1'b0;
        shift_d = {shift_cur[6:0], 1'b0};
      end
      PH_RD_HIGH: begin
        scl_d = 1'b1;
        shift_d = {shift_cur[7:1], shift_cur[0] | sda_sample_i};
        bit_cnt_d = bit_cnt_inc;
      end
      PH_AK_SET: begin
        scl_d = 1'b0;
        if (act_cmd_d == CMD_ACK) begin
          sda_drv_d = 1'b1; sda_lvl_d = 1'b0;
        end else begin
          sda_drv_d = 1'b0; sda_lvl_d = 1'b1;
        end
      end
      PH_AK_HIGH: scl_d = 1'b1;
      PH_FINISH: begin
        scl_d = 1'b0; done = 1'b1;
        if (act_cmd_d == CMD_READ) last_read_d = shift_cur;
      end
      default: ;
    endcase
  end

  // Hold the timeout register; a running wait keeps the count it loaded
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ack_timeout_q <= AckTimeoutReset;
    end else if (cfg_we_i) begin
      ack_timeout_q <= cfg_wdata_i;
    end
  end

  // Advance the sequencer state on each accepted tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      bit_cnt_q   <= 4'd0;
      shift_q     <= 8'd0;
      tmo_q       <= 8'd0;
      act_cmd_q   <= 3'd0;
      scl_q       <= 1'b1;
      sda_drv_q   <= 1'b1;
      sda_lvl_q   <= 1'b1;
      last_read_q <= 8'd0;
      ack_fail_q  <= 1'b0;
    end else if (accept) begin
      phase_q     <= phase_d;
      bit_cnt_q   <= bit_cnt_d;
      shift_q     <= shift_d;
      tmo_q       <= tmo_d;
      act_cmd_q   <= act_cmd_d;
      scl_q       <= scl_d;
      sda_drv_q   <= sda_drv_d;
      sda_lvl_q   <= sda_lvl_d;
      last_read_q <= last_read_d;
      ack_fail_q  <= ack_fail_d;
    end
  end

  // Result register valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  // Result payload: load with the tick's outputs
  always_ff @(posedge clk_i) begin
    if (accept) begin
      scl_level_o   <= scl_d;
      sda_drive_o   <= sda_drv_d;
      sda_level_o   <= sda_lvl_d;
      ready_res_o   <= idle;
      done_res_o    <= done;
      read_value_o  <= last_read_d;
      ack_missing_o <= ack_fail_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

### design/i2cms_checker.sv
// Port-level checker for the I2C master bit sequencer, bound to the top level.
// Depends on i2c_master_bit_sequencer_macros.svh.
`include "i2c_master_bit_sequencer_macros.svh"

module i2cms_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       cfg_we_i,
  input logic [7:0] cfg_wdata_i,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       cmd_valid_i,
  input logic [2:0] command_i,
  input logic [7:0] write_data_i,
  input logic       sda_sample_i,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic       scl_level_o,
  input logic       sda_drive_o,
  input logic       sda_level_o,
  input logic       ready_res_o,
  input logic       done_res_o,
  input logic [7:0] read_value_o,
  input logic       ack_missing_o
);

  // A stalled result transaction stays offered
  `I2CMS_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o, "result dropped")

  // A stalled result transaction keeps its read value, done flag and SCL level
  `I2CMS_ASSERT_NEXT(a_out_stable, out_valid_o && !out_ready_i,
    $stable(read_value_o) && $stable(done_res_o) && $stable(scl_level_o), "result changed")

  // Input side stalls only behind a full result register
  `I2CMS_ASSERT_NOW(a_in_stall, !in_ready_o, out_valid_o, "input stalled with empty output")

  // Every command takes at least two ticks, so done never comes on a dispatch tick
  `I2CMS_ASSERT_NOW(a_done_busy, out_valid_o && done_res_o, !ready_res_o, "done while idle")

endmodule

bind i2c_master_bit_sequencer i2cms_checker u_i2cms_checker (.*);

### sim/i2c_master_bit_sequencer_test.sv
// Self-checking testbench for the I2C master bit sequencer: directed table, then framed random traffic.
// Compares each pin result in order with a prediction or typed row pins; uses i2cms_pkg and the DUT.
module i2c_master_bit_sequencer_test;
  import i2cms_pkg::*;

  localparam logic [2:0] CMD_UNUSED  = 3'd7;
  localparam int         PHASES      = 14;
  localparam int         PHASE_ITEMS = 75;
  localparam int         HOLD_PHASE  = 4;
  localparam int         HOLD_CYCLES = 400;
  localparam int         QUIET_LIMIT = 4000;
  localparam int         TAIL_CYCLES = 8;

  typedef struct packed {
    logic       cv;
    logic [2:0] cmd;
    logic [7:0] wd;
    logic       sda;
  } tick_t;

  typedef struct packed {
    logic       scl;
    logic       drv;
    logic       lvl;
    logic       rdy;
    logic       done;
    logic [7:0] rbyte;
    logic       nak;
  } pins_t;

  typedef struct packed {
    logic       set_tmo;
    logic [7:0] tmo_val;
    logic       cv;
    logic [2:0] cmd;
    logic [7:0] wd;
    logic       sda;
    logic       typed;
    logic [5:0] pins;   // scl drv lvl rdy done nak, read byte still zero
  } dir_row_t;

  // Directed ticks; a set timeout bit rewrites the register before that row
  localparam dir_row_t DIR_ROWS [26] = '{
    //  set  value  valid command     data   sda   typed  pins
    '{1'b0, 8'd0, 1'b0, CMD_START,  8'h00, 1'b1, 1'b1, 6'b111100},  // idle after reset
    '{1'b0, 8'd0, 1'b1, CMD_UNUSED, 8'hFF, 1'b0, 1'b1, 6'b111100},  // unused code, stays idle
    '{1'b0, 8'd0, 1'b1, CMD_START,  8'h00, 1'b1, 1'b1, 6'b111100},  // start, both lines high
    '{1'b0, 8'd0, 1'b1, CMD_STOP,   8'hFF, 1'b0, 1'b1, 6'b110010},  // offer while busy dropped
    '{1'b0, 8'd0, 1'b1, CMD_STOP,   8'h00, 1'b1, 1'b1, 6'b110100},
    '{1'b0, 8'd0, 1'b0, CMD_READ,   8'hFF, 1'b0, 1'b1, 6'b111010},
    '{1'b0, 8'd0, 1'b1, CMD_ACK,    8'h00, 1'b1, 1'b1, 6'b010100},
    '{1'b0, 8'd0, 1'b0, CMD_START,  8'h00, 1'b0, 1'b1, 6'b110000},
    '{1'b0, 8'd0, 1'b0, CMD_START,  8'h00, 1'b1, 1'b1, 6'b010010},
    '{1'b0, 8'd0, 1'b1, CMD_NACK,   8'hFF, 1'b0, 1'b1, 6'b001100},
    '{1'b0, 8'd0, 1'b0, CMD_START,  8'h00, 1'b1, 1'b1, 6'b101000},
    '{1'b0, 8'd0, 1'b0, CMD_START,  8'h00, 1'b0, 1'b1, 6'b001010},
    // wait acked on the first poll
    '{1'b0, 8'd0, 1'b1, CMD_WAIT,   8'h00, 1'b1, 1'b0, 6'b000000},
    '{1'b0, 8'd0, 1'b0, CMD_START,  8'h00, 1'b0, 1'b0, 6'b000000},
    '{1'b0, 8'd0, 1'b0, CMD_START,  8'h00, 1'b1, 1'b0, 6'b000000},
    '{1'b0, 8'd0, 1'b0, CMD_START,  8'h00, 1'b0, 1'b0, 6'b000000},
    // timeout rewritten while polling; the running wait keeps its count
    '{1'b0, 8'd0, 1'b1, CMD_WAIT,   8'h00, 1'b0, 1'b0, 6'b000000},
    '{1'b0, 8'd0, 1'b0, CMD_START,  8'h00, 1'b1, 1'b0, 6'b000000},
    '{1'b1, 8'd1, 1'b0, CMD_START,  8'h00, 1'b1, 1'b0, 6'b000000},
    '{1'b0, 8'd0, 1'b0, CMD_START,  8'h00, 1'b0, 1'b0, 6'b000000},
    '{1'b0, 8'd0, 1'b0, CMD_START,  8'h00, 1'b1, 1'b0, 6'b000000},
    '{1'b0, 8'd0, 1'b0, CMD_START,  8'h00, 1'b0, 1'b0, 6'b000000},
    // next wait gives up after one high sample
    '{1'b0, 8'd0, 1'b1, CMD_WAIT,   8'h00, 1'b1, 1'b0, 6'b000000},
    '{1'b0, 8'd0, 1'b0, CMD_START,  8'hFF, 1'b1, 1'b1, 6'b101001},
    '{1'b0, 8'd0, 1'b0, CMD_START,  8'h00, 1'b0, 1'b1, 6'b001011},
    '{1'b0, 8'd0, 1'b1, CMD_READ,   8'h00, 1'b1, 1'b0, 6'b000000}
  };

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [7:0] cfg_wdata_i;
  logic       in_valid_i;
  logic       in_ready_o;
  logic       cmd_valid_i;
  logic [2:0] command_i;
  logic [7:0] write_data_i;
  logic       sda_sample_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic       scl_level_o;
  logic       sda_drive_o;
  logic       sda_level_o;
  logic       ready_res_o;
  logic       done_res_o;
  logic [7:0] read_value_o;
  logic       ack_missing_o;

  // Predicted sequencer state
  phase_e     bus_phase;
  logic [3:0] bit_cnt;
  logic [7:0] shift_byte;
  logic [7:0] ack_countdown;
  logic [7:0] ack_timeout_cfg;
  logic [2:0] held_cmd;
  logic       scl_q;
  logic       sda_drv_q;
  logic       sda_lvl_q;
  logic [7:0] last_rx_byte;
  logic       ack_missed_q;

  pins_t pins_due [$];
  int    pin_errors;
  int    results_seen;
  bit    hold_off_req;

  i2c_master_bit_sequencer uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .cmd_valid_i  (cmd_valid_i),
    .command_i    (command_i),
    .write_data_i (write_data_i),
    .sda_sample_i (sda_sample_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .scl_level_o  (scl_level_o),
    .sda_drive_o  (sda_drive_o),
    .sda_level_o  (sda_level_o),
    .ready_res_o  (ready_res_o),
    .done_res_o   (done_res_o),
    .read_value_o (read_value_o),
    .ack_missing_o(ack_missing_o)
  );

  always #1 clk_i = ~clk_i;

  // Advance the predicted sequencer by one tick and return its pins and status
  function automatic pins_t advance_bus(input tick_t t);
    pins_t r;
    logic  was_idle;
    was_idle = (bus_phase == PH_IDLE);
    r = '0;
    if (was_idle && t.cv && t.cmd != CMD_UNUSED) begin
      held_cmd   = t.cmd;
      bit_cnt    = '0;
      shift_byte = (t.cmd == CMD_WRITE) ? t.wd : 8'h00;
      case (t.cmd)
        CMD_START: bus_phase = PH_S_A;
        CMD_STOP:  bus_phase = PH_P_A;
        CMD_WRITE: bus_phase = PH_WR_LOW;
        CMD_WAIT:  bus_phase = PH_WA_RISE;
        CMD_READ:  bus_phase = PH_RD_LOW;
        default:   bus_phase = PH_AK_SET;
      endcase
    end
    case (bus_phase)
      PH_S_A: begin
        sda_drv_q = 1'b1; sda_lvl_q = 1'b1; scl_q = 1'b1;
        bus_phase = PH_S_B;
      end
      PH_S_B: begin
        sda_lvl_q = 1'b0; r.done = 1'b1;
        bus_phase = PH_IDLE;
      end
      PH_P_A: begin
        sda_drv_q = 1'b1; sda_lvl_q = 1'b0; scl_q = 1'b1;
        bus_phase = PH_P_B;
      end
      PH_P_B: begin
        sda_lvl_q = 1'b1; r.done = 1'b1;
        bus_phase = PH_IDLE;
      end
      PH_WR_LOW: begin
        scl_q = 1'b0; sda_drv_q = 1'b1;
        sda_lvl_q  = shift_byte[7];
        shift_byte = {shift_byte[6:0], 1'b0};
        bus_phase  = PH_WR_HIGH;
      end
      PH_WR_HIGH: begin
        scl_q = 1'b1;
        bit_cnt++;
        bus_phase = (bit_cnt >= BitsPerByte) ? PH_FINISH : PH_WR_LOW;
      end
      PH_WA_RISE: begin
        sda_drv_q = 1'b0; scl_q = 1'b1;
        ack_countdown = ack_timeout_cfg;
        bus_phase = PH_WA_POLL;
      end
      PH_WA_POLL: begin
        scl_q = 1'b1;
        if (t.sda) begin
          ack_countdown--;
          if (ack_countdown == 8'h00) begin
            ack_missed_q = 1'b1;
            bus_phase = PH_FINISH;
          end
        end else begin
          ack_missed_q = 1'b0;
          bus_phase = PH_WA_HOLD;
        end
      end
      PH_WA_HOLD: begin
        scl_q = 1'b1;
        bus_phase = PH_FINISH;
      end
      PH_RD_LOW: begin
        sda_drv_q = 1'b0; sda_lvl_q = 1'b1; scl_q = 1'b0;
        shift_byte = {shift_byte[6:0], 1'b0};
        bus_phase = PH_RD_HIGH;
      end
      PH_RD_HIGH: begin
        scl_q = 1'b1;
        if (t.sda) shift_byte[0] = 1'b1;
        bit_cnt++;
        bus_phase = (bit_cnt >= BitsPerByte) ? PH_FINISH : PH_RD_LOW;
      end
      PH_AK_SET: begin
        scl_q = 1'b0;
        if (held_cmd == CMD_ACK) begin
          sda_drv_q = 1'b1; sda_lvl_q = 1'b0;
        end else begin
          sda_drv_q = 1'b0; sda_lvl_q = 1'b1;
        end
        bus_phase = PH_AK_HIGH;
      end
      PH_AK_HIGH: begin
        scl_q = 1'b1;
        bus_phase = PH_FINISH;
      end
      PH_FINISH: begin
        scl_q = 1'b0; r.done = 1'b1;
        if (held_cmd == CMD_READ) last_rx_byte = shift_byte;
        bus_phase = PH_IDLE;
      end
      default: bus_phase = PH_IDLE;
    endcase
    r.scl   = scl_q;
    r.drv   = sda_drv_q;
    r.lvl   = sda_lvl_q;
    r.rdy   = was_idle;
    r.rbyte = last_rx_byte;
    r.nak   = ack_missed_q;
    return r;
  endfunction

  function automatic string pins_text(input pins_t p);
    return $sformatf("scl=%b drv=%b lvl=%b rdy=%b done=%b byte=%h nak=%b",
                     p.scl, p.drv, p.lvl, p.rdy, p.done, p.rbyte, p.nak);
  endfunction

  // Offer one tick, hold it until taken, then queue its expected pins
  task automatic send_tick(input tick_t t, input logic typed, input pins_t want);
    pins_t predicted;
    in_valid_i   <= 1'b1;
    cmd_valid_i  <= t.cv;
    command_i    <= t.cmd;
    write_data_i <= t.wd;
    sda_sample_i <= t.sda;
    do @(posedge clk_i); while (!in_ready_o);
    predicted = advance_bus(t);
    pins_due.push_back(typed ? want : predicted);
  endtask

  // Stop offering and wait until every queued result has come back
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pins_due.size() != 0);
  endtask

  task automatic set_ack_timeout(input logic [7:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    ack_timeout_cfg = value;
    repeat (2) @(posedge clk_i);
  endtask

  // Main stimulus: reset, directed table, then random frames over several timeouts
  initial begin : stimulus
    tick_t      t;
    pins_t      want;
    cmd_e       frame_q [$];
    logic [7:0] tmo;
    bit         gappy;
    bit         force_nak;
    bit         hold_nak;
    bit         reading;
    int         rd_style;
    int         sent;
    int         burst_left;
    int         n;

    clk_i = 1'b0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = 8'h00;
    in_valid_i = 1'b0;
    cmd_valid_i = 1'b0;
    command_i = CMD_START;
    write_data_i = 8'h00;
    sda_sample_i = 1'b1;
    out_ready_i = 1'b0;
    hold_off_req = 1'b0;
    pin_errors = 0;
    results_seen = 0;

    bus_phase = PH_IDLE;
    bit_cnt = '0;
    shift_byte = '0;
    ack_countdown = '0;
    ack_timeout_cfg = AckTimeoutReset;
    held_cmd = CMD_START;
    scl_q = 1'b1;
    sda_drv_q = 1'b1;
    sda_lvl_q = 1'b1;
    last_rx_byte = '0;
    ack_missed_q = 1'b0;
    force_nak = 1'b0;
    hold_nak = 1'b0;
    rd_style = 0;
    burst_left = 0;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed table
    for (int i = 0; i < $size(DIR_ROWS); i++) begin
      if (DIR_ROWS[i].set_tmo) begin
        drain_results();
        set_ack_timeout(DIR_ROWS[i].tmo_val);
      end
      t = '{DIR_ROWS[i].cv, DIR_ROWS[i].cmd, DIR_ROWS[i].wd, DIR_ROWS[i].sda};
      want = '{DIR_ROWS[i].pins[5], DIR_ROWS[i].pins[4], DIR_ROWS[i].pins[3],
               DIR_ROWS[i].pins[2], DIR_ROWS[i].pins[1], 8'h00, DIR_ROWS[i].pins[0]};
      send_tick(t, DIR_ROWS[i].typed, want);
    end

    // Random phases, each with its own acknowledge timeout
    for (int ph = 0; ph < PHASES; ph++) begin
      drain_results();
      case (ph)
        0:       tmo = 8'd1;
        1:       tmo = 8'd255;
        2:       tmo = 8'd0;
        default: tmo = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(17, 254))
                                                   : 8'($urandom_range(1, 16));
      endcase
      set_ack_timeout(tmo);
      force_nak = (ph == 1 || ph == 2);
      if (ph == HOLD_PHASE) hold_off_req = 1'b1;
      gappy = (ph % 3 != 2);
      sent = 0;
      while (sent < PHASE_ITEMS || bus_phase != PH_IDLE || force_nak) begin
        t.wd = 8'($urandom);
        t.sda = 1'($urandom_range(0, 1));
        if (bus_phase == PH_IDLE) begin
          if ($urandom_range(0, 7) == 0) begin
            // idle tick or the unused code
            t.cv = 1'($urandom_range(0, 1));
            t.cmd = t.cv ? CMD_UNUSED : 3'($urandom);
          end else begin
            if (frame_q.size() == 0) begin
              frame_q.push_back(CMD_START);
              frame_q.push_back(CMD_WRITE);
              frame_q.push_back(CMD_WAIT);
              reading = 1'($urandom_range(0, 1));
              n = $urandom_range(1, 3);
              for (int k = 0; k < n; k++) begin
                if (reading) begin
                  frame_q.push_back(CMD_READ);
                  frame_q.push_back((k == n - 1) ? CMD_NACK : CMD_ACK);
                end else begin
                  frame_q.push_back(CMD_WRITE);
                  frame_q.push_back(CMD_WAIT);
                end
              end
              frame_q.push_back(CMD_STOP);
            end
            t.cv = 1'b1;
            if ($urandom_range(0, 9) == 0) t.cmd = 3'($urandom_range(0, 6));
            else t.cmd = frame_q.pop_front();
            case ($urandom_range(0, 7))
              0:       t.wd = 8'h00;
              1:       t.wd = 8'hFF;
              default: ;
            endcase
            if (t.cmd == CMD_WAIT) begin
              hold_nak = force_nak || (ack_timeout_cfg inside {[8'd1:8'd16]} &&
                                       $urandom_range(0, 2) == 0);
              force_nak = 1'b0;
            end
            if (t.cmd == CMD_READ) rd_style = $urandom_range(0, 3);
          end
        end else begin
          // busy: offers are noise
          t.cv = 1'($urandom_range(0, 1));
          t.cmd = 3'($urandom);
          if (bus_phase == PH_WA_POLL)
            t.sda = hold_nak ? 1'b1 : ($urandom_range(0, 3) != 0);
          else if (bus_phase == PH_RD_HIGH && rd_style == 1)
            t.sda = 1'b0;
          else if (bus_phase == PH_RD_HIGH && rd_style == 2)
            t.sda = 1'b1;
        end
        send_tick(t, 1'b0, '0);
        sent++;
        // Bursts with random gaps
        if (gappy) begin
          if (burst_left == 0) begin
            in_valid_i <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk_i);
            burst_left = $urandom_range(1, 40);
          end else begin
            burst_left--;
          end
        end
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (pin_errors == 0 && pins_due.size() == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  // Result-side ready: rotating stall patterns, plus one long hold-off on request
  initial begin : drain_pattern
    logic [15:0] stall_pat;
    int          beat;
    stall_pat = 16'hFFFF;
    beat = 0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_off_req = 1'b0;
        out_ready_i <= 1'b1;
      end else begin
        if (beat % 64 == 0) begin
          case ($urandom_range(0, 3))
            0:       stall_pat = 16'hFFFF;
            1:       stall_pat = 16'($urandom);
            2:       stall_pat = 16'($urandom) | 16'($urandom);
            default: stall_pat = 16'($urandom) & 16'($urandom);
          endcase
        end
        out_ready_i <= stall_pat[0];
        stall_pat = {stall_pat[0], stall_pat[15:1]};
        beat++;
      end
    end
  end

  // Compare each taken result with the oldest expectation
  always @(posedge clk_i) begin : check_pins
    pins_t got;
    pins_t want;
    string bad;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{scl_level_o, sda_drive_o, sda_level_o, ready_res_o, done_res_o,
              read_value_o, ack_missing_o};
      results_seen++;
      if (pins_due.size() == 0) begin
        pin_errors++;
        if (pin_errors <= 10)
          $display("result %0d: none was due, got %s", results_seen, pins_text(got));
      end else begin
        want = pins_due.pop_front();
        bad = "";
        if (got.scl !== want.scl)     bad = {bad, " scl"};
        if (got.drv !== want.drv)     bad = {bad, " sda_drive"};
        if (got.lvl !== want.lvl)     bad = {bad, " sda_level"};
        if (got.rdy !== want.rdy)     bad = {bad, " ready"};
        if (got.done !== want.done)   bad = {bad, " done"};
        if (got.rbyte !== want.rbyte) bad = {bad, " read_value"};
        if (got.nak !== want.nak)     bad = {bad, " ack_missing"};
        if (bad != "") begin
          pin_errors++;
          if (pin_errors <= 10) begin
            $display("result %0d mismatch:%s", results_seen, bad);
            $display("  expected %s", pins_text(want));
            $display("  actual   %s", pins_text(got));
          end
        end
      end
    end
  end

  // Watchdog: end the run when no transaction moves for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    @(posedge rst_ni);
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
    end
    $display("CHECK FAILED");
    $finish;
  end

endmodule

### sim.f
+incdir+design
design/i2cms_pkg.sv
design/i2c_master_bit_sequencer.sv
design/i2cms_checker.sv
sim/i2c_master_bit_sequencer_test.sv
